### hw/rtl/sorted_priority_queue_unit_macros.svh
// Assertion macros for the sorted priority queue unit.
// Included by the top level; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");
// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue unit.
// No dependencies; imported by the controller, datapath and top level.
package spq_pkg;

   localparam int DEPTH     = 128;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = 8;
   localparam int TAG_W     = 16;
   localparam int KEY_W     = 32;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(128);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Request actions.
   localparam logic ACT_PUT = 1'b0;
   localparam logic ACT_GET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_POP,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Which logical slot the memory read targets.
   typedef enum logic [1:0] {
      RD_LAST,
      RD_BELOW,
      RD_HEAD
   } rd_sel_type;

   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      logic signed [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       shift;
      logic       place;
      logic       pop;
   } cmd_type;

   typedef struct packed {
      logic req_put;
      logic full;
      logic empty;
      logic less;
      logic pos_one;
   } status_type;

endpackage

### hw/rtl/spq_ctrl.sv
// Controller state machine for the sorted priority queue unit.
// Depends on spq_pkg; drives the datapath through cmd_type.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       strobe
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_HEAD;
      busy       = 1'b1;
      strobe     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (status.req_put) begin
                  if (status.full) begin
                     state_in = ST_FINISH;
                  end else if (status.empty) begin
                     state_in = ST_PLACE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = ST_SCAN;
                  end
               end else if (status.empty) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_HEAD;
                  state_in   = ST_POP;
               end
            end
         end
         ST_SCAN: begin
            // The read data holds the entry just below the insertion point.
            if (status.less) begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.shift = 1'b1;
               if (status.pos_one) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_BELOW;
               end
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Fetch the head entry for the reported best key.
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            strobe   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue unit: entry memory, pointers, result registers.
// Depends on spq_pkg; controlled by spq_ctrl through cmd_type.
module spq_datapath
   import spq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_action,
   input  logic [TAG_W-1:0]        req_item_tag,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic                    csr_valid,
   input  logic [CNT_W-1:0]        csr_capacity_limit,
   output logic                    rsp_out_valid,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic signed [KEY_W-1:0] rsp_out_key,
   output logic                    rsp_overflow,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic signed [KEY_W-1:0] rsp_best_key,
   output logic                    rsp_is_empty
);

   // Entries live in a ring; logical slot 0 is the head.
   entry_type mem [DEPTH];

   logic [ADDR_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  cap_ff;
   entry_type         new_ff;
   entry_type         rdata_ff;
   logic              out_valid_ff;
   entry_type         out_ff;
   logic              ovf_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              full;

   // Full when at the programmed limit or at the physical depth.
   assign full = (count_ff >= cap_ff) || (count_ff >= DEPTH_CNT);

   assign status.req_put = (req_action == ACT_PUT);
   assign status.full    = full;
   assign status.empty   = (count_ff == '0);
   assign status.less    = (rdata_ff.key < new_ff.key);
   assign status.pos_one = (pos_ff == CNT_W'(1));

   // Read address per command.
   always_comb begin
      case (cmd.rd_sel)
         RD_LAST:  rd_addr = head_ff + count_ff[ADDR_W-1:0] - ADDR_W'(1);
         RD_BELOW: rd_addr = head_ff + pos_ff[ADDR_W-1:0] - ADDR_W'(2);
         RD_HEAD:  rd_addr = head_ff;
         default:  rd_addr = head_ff;
      endcase
   end

   assign wr_addr = head_ff + pos_ff[ADDR_W-1:0];

   // Entry memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         mem[wr_addr] <= rdata_ff;
      end else if (cmd.place) begin
         mem[wr_addr] <= new_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control state: pointers, count and the capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_capacity_limit;
         end
         if (cmd.load) begin
            pos_ff <= count_ff;
         end else if (cmd.shift) begin
            pos_ff <= pos_ff - CNT_W'(1);
         end
         if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CNT_W'(1);
            head_ff  <= head_ff + ADDR_W'(1);
         end
      end
   end

   // Request capture and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_ff.tag   <= req_item_tag;
         new_ff.key   <= req_key;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
         ovf_ff       <= (req_action == ACT_PUT) && full;
      end else if (cmd.pop) begin
         out_valid_ff <= 1'b1;
         out_ff       <= rdata_ff;
      end
   end

   assign rsp_out_valid   = out_valid_ff;
   assign rsp_out_tag     = out_ff.tag;
   assign rsp_out_key     = out_ff.key;
   assign rsp_overflow    = ovf_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_best_key    = (count_ff == '0) ? '0 : rdata_ff.key;

endmodule

### hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue unit.
// Depends on spq_pkg, spq_ctrl, spq_datapath and the assertion macro header.
//
//   Channel   Handshake                  Payload
//   request   start && !busy             req_action, req_item_tag, req_key
//   result    rsp_strobe (one cycle)     rsp_out_valid .. rsp_is_empty
//   csr       csr_valid && csr_ready     csr_capacity_limit
//
// A get passes through ST_POP, ST_FINISH and ST_DONE before rsp_strobe; a put
// moves up each stored entry with a key not below the new key, in ST_SCAN, at
// one memory read and one write per cycle on the entry RAM, then places the new
// entry. Overflowed puts and empty-queue gets go only to ST_FINISH and ST_DONE.
// Reset is synchronous and clears the queue and sets the capacity to 128.
// The receiver cannot stall; busy stays high until the result strobe.
`include "sorted_priority_queue_unit_macros.svh"
module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [TAG_W-1:0]        req_item_tag,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_strobe,
   output logic                    rsp_out_valid,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic signed [KEY_W-1:0] rsp_out_key,
   output logic                    rsp_overflow,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic signed [KEY_W-1:0] rsp_best_key,
   output logic                    rsp_is_empty,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CNT_W-1:0]        csr_capacity_limit
);

   cmd_type    cmd;
   status_type status;

   // The capacity register takes a write in any cycle.
   assign csr_ready = 1'b1;

   spq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   spq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_item_tag       (req_item_tag),
      .req_key            (req_key),
      .csr_valid          (csr_valid),
      .csr_capacity_limit (csr_capacity_limit),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_out_key        (rsp_out_key),
      .rsp_overflow       (rsp_overflow),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_best_key       (rsp_best_key),
      .rsp_is_empty       (rsp_is_empty)
   );

   // An accepted request keeps the unit busy in the following cycle.
   `SPQ_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // A removed entry and a dropped put never appear in one result.
   `SPQ_ASSERT_NOW(a_valid_ovf, clock, reset, rsp_strobe && rsp_out_valid, !rsp_overflow)
   // An empty queue reports a zero best key and a zero count.
   `SPQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_strobe && rsp_is_empty,
                   (rsp_best_key == '0) && (rsp_entry_count == '0))

endmodule
